// File: rtl/qghc_pkg.sv
`default_nettype none
package qghc_pkg;

    // register file
    localparam int CFG_BITS     = 24;
    localparam int CFG_IDX_BITS = 2;
    localparam logic [CFG_IDX_BITS-1:0] REG_MIN_AB = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_MAX_AB = 2'd1;

    // parameter defaults
    localparam int COORD_BITS_DEF     = 24;
    localparam int CODE_FRAC_BITS_DEF = 16;
    localparam int INDEX_BITS_DEF     = 10;

    // result status
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_AB_RANGE = 2'd1;
    localparam logic [1:0] ST_BOX      = 2'd2;

    // star orders
    localparam logic [1:0] ORD_ABCD = 2'd0;
    localparam logic [1:0] ORD_BACD = 2'd1;
    localparam logic [1:0] ORD_ABDC = 2'd2;
    localparam logic [1:0] ORD_BADC = 2'd3;

endpackage
`default_nettype wire

// File: rtl/qghc_if.sv
`default_nettype none
// quad input channel
interface qghc_quad_if #(parameter int CB = 24, parameter int IB = 10);
    logic valid;
    logic ready;
    logic [CB-1:0] ax;
    logic [CB-1:0] ay;
    logic [CB-1:0] bx;
    logic [CB-1:0] by_pos;
    logic [CB-1:0] cx;
    logic [CB-1:0] cy;
    logic [CB-1:0] dx_pos;
    logic [CB-1:0] dy_pos;
    logic [IB-1:0] a_index;
    logic [IB-1:0] b_index;
    logic [IB-1:0] c_index;
    logic [IB-1:0] d_index;
    modport source (output valid, ax, ay, bx, by_pos, cx, cy, dx_pos, dy_pos,
                    a_index, b_index, c_index, d_index, input ready);
    modport sink (input valid, ax, ay, bx, by_pos, cx, cy, dx_pos, dy_pos,
                  a_index, b_index, c_index, d_index, output ready);
endinterface

// code result channel
interface qghc_code_if #(parameter int FB = 16, parameter int IB = 10);
    logic valid;
    logic ready;
    logic [1:0] status;
    logic [1:0] order;
    logic [FB:0] code_0;
    logic [FB:0] code_1;
    logic [FB:0] code_2;
    logic [FB:0] code_3;
    logic [IB-1:0] first_star;
    logic [IB-1:0] second_star;
    logic [IB-1:0] third_star;
    logic [IB-1:0] fourth_star;
    logic last;
    modport source (output valid, status, order, code_0, code_1, code_2, code_3,
                    first_star, second_star, third_star, fourth_star, last,
                    input ready);
    modport sink (input valid, status, order, code_0, code_1, code_2, code_3,
                  first_star, second_star, third_star, fourth_star, last,
                  output ready);
endinterface

// register write channel
interface qghc_cfg_if #(parameter int XB = 2, parameter int DB = 24);
    logic valid;
    logic ready;
    logic [XB-1:0] index;
    logic [DB-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: rtl/qghc_div_pipe.sv
`default_nettype none
// Pipelined restoring divider: four numerators over one shared divisor,
// one quotient bit per stage, quotient = floor(n * 2^FB / s) for n < s.
module qghc_div_pipe #(
    parameter int SW = 50,
    parameter int FB = 16,
    parameter int PW = 42
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          en,
    input  wire logic          in_valid,
    input  wire logic [SW-1:0] in_s,
    input  wire logic [SW-1:0] in_n [4],
    input  wire logic [PW-1:0] in_pay,
    output logic               out_valid,
    output logic [FB-1:0]      out_q [4],
    output logic [PW-1:0]      out_pay
);
    logic [FB-1:0] v_reg;
    logic [SW-1:0] s_reg [FB];
    logic [SW-1:0] r_reg [FB][4];
    logic [FB-1:0] q_reg [FB][4];
    logic [PW-1:0] p_reg [FB];

    for (genvar k = 0; k < FB; k++) begin : g_stage
        logic          v_src;
        logic [SW-1:0] s_src;
        logic [SW-1:0] r_src [4];
        logic [FB-1:0] q_src [4];
        logic [PW-1:0] p_src;
        logic [SW-1:0] r_next [4];
        logic [FB-1:0] q_next [4];

        if (k == 0) begin : g_first
            always_comb
            begin
                v_src = in_valid;
                s_src = in_s;
                p_src = in_pay;
                for (int j = 0; j < 4; j++)
                begin
                    r_src[j] = in_n[j];
                    q_src[j] = '0;
                end
            end
        end else begin : g_rest
            always_comb
            begin
                v_src = v_reg[k-1];
                s_src = s_reg[k-1];
                p_src = p_reg[k-1];
                for (int j = 0; j < 4; j++)
                begin
                    r_src[j] = r_reg[k-1][j];
                    q_src[j] = q_reg[k-1][j];
                end
            end
        end

        // shift, trial subtract, quotient bit
        always_comb
        begin
            logic [SW:0] wide;
            logic [SW:0] diff;
            for (int j = 0; j < 4; j++)
            begin
                wide = {r_src[j], 1'b0};
                diff = wide - {1'b0, s_src};
                if (wide >= {1'b0, s_src})
                begin
                    r_next[j] = diff[SW-1:0];
                    q_next[j] = {q_src[j][FB-2:0], 1'b1};
                end
                else
                begin
                    r_next[j] = wide[SW-1:0];
                    q_next[j] = {q_src[j][FB-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[k] <= v_src;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                s_reg[k] <= s_src;
                p_reg[k] <= p_src;
                for (int j = 0; j < 4; j++)
                begin
                    r_reg[k][j] <= r_next[j];
                    q_reg[k][j] <= q_next[j];
                end
            end
        end
    end

    assign out_valid = v_reg[FB-1];
    assign out_pay   = p_reg[FB-1];
    always_comb
    begin
        for (int j = 0; j < 4; j++)
        begin
            out_q[j] = q_reg[FB-1][j];
        end
    end
endmodule
`default_nettype wire

// File: rtl/quad_geometric_hash_code.sv
// A quad passes the arithmetic stages, the divider stages and the result register.
// Throughput: a quad enters every cycle while no finished record waits on the
//   serialiser; an accepted quad gives four result transfers, a rejected quad one.
// The single result register set by the 4-way serialiser fixes the sustained rate.
// Reset (rst_n low, asynchronous): pipeline empty, min_ab = 0, max_ab = all ones.
`default_nettype none
module quad_geometric_hash_code #(
    parameter int COORD_BITS     = qghc_pkg::COORD_BITS_DEF,
    parameter int CODE_FRAC_BITS = qghc_pkg::CODE_FRAC_BITS_DEF,
    parameter int INDEX_BITS     = qghc_pkg::INDEX_BITS_DEF
) (
    input wire logic clk,
    input wire logic rst_n,
    qghc_quad_if.sink   quad_in,
    qghc_code_if.source code_out,
    qghc_cfg_if.sink    cfg
);
    import qghc_pkg::*;

    localparam int CB = COORD_BITS;
    localparam int FB = CODE_FRAC_BITS;
    localparam int IB = INDEX_BITS;
    localparam int D  = CB + 1;
    localparam int SW = 2 * D;
    localparam int UW = 2 * D + 2;
    localparam int M2 = 2 * CFG_BITS;
    localparam int MW = (SW > M2) ? SW : M2;
    localparam int PW = 2 + 4 * IB;

    logic adv;

    // configuration registers
    logic [CFG_BITS-1:0] min_ab_reg;
    logic [CFG_BITS-1:0] max_ab_reg;
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_ab_reg <= '0;
            max_ab_reg <= '1;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_MIN_AB: min_ab_reg <= cfg.data;
                REG_MAX_AB: max_ab_reg <= cfg.data;
                default:    ;
            endcase
        end
    end

    // stage valid bits
    logic [4:0] v_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[3:0], quad_in.valid};
        end
    end

    // stage 1: differences from A
    logic signed [D-1:0] dx1_reg, dy1_reg, ecx1_reg, ecy1_reg, edx1_reg, edy1_reg;
    logic [4*IB-1:0]     idx1_reg, idx2_reg, idx3_reg, idx4_reg, idx5_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dx1_reg  <= $signed({quad_in.bx[CB-1], quad_in.bx})
                      - $signed({quad_in.ax[CB-1], quad_in.ax});
            dy1_reg  <= $signed({quad_in.by_pos[CB-1], quad_in.by_pos})
                      - $signed({quad_in.ay[CB-1], quad_in.ay});
            ecx1_reg <= $signed({quad_in.cx[CB-1], quad_in.cx})
                      - $signed({quad_in.ax[CB-1], quad_in.ax});
            ecy1_reg <= $signed({quad_in.cy[CB-1], quad_in.cy})
                      - $signed({quad_in.ay[CB-1], quad_in.ay});
            edx1_reg <= $signed({quad_in.dx_pos[CB-1], quad_in.dx_pos})
                      - $signed({quad_in.ax[CB-1], quad_in.ax});
            edy1_reg <= $signed({quad_in.dy_pos[CB-1], quad_in.dy_pos})
                      - $signed({quad_in.ay[CB-1], quad_in.ay});
            idx1_reg <= {quad_in.a_index, quad_in.b_index,
                         quad_in.c_index, quad_in.d_index};
        end
    end

    // stage 2: squares, frame axes, squared limits
    logic signed [SW-1:0] sqx2_reg, sqy2_reg;
    logic signed [D:0]    p2_reg, m2_reg;
    logic signed [D-1:0]  ecx2_reg, ecy2_reg, edx2_reg, edy2_reg;
    logic [M2-1:0]        min2_reg, max2_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sqx2_reg <= dx1_reg * dx1_reg;
            sqy2_reg <= dy1_reg * dy1_reg;
            p2_reg   <= D'(dx1_reg) + D'(dy1_reg) + (D+1)'(0);
            m2_reg   <= (D+1)'(dy1_reg) - (D+1)'(dx1_reg);
            ecx2_reg <= ecx1_reg;
            ecy2_reg <= ecy1_reg;
            edx2_reg <= edx1_reg;
            edy2_reg <= edy1_reg;
            min2_reg <= M2'(min_ab_reg) * M2'(min_ab_reg);
            max2_reg <= M2'(max_ab_reg) * M2'(max_ab_reg);
            idx2_reg <= idx1_reg;
        end
    end

    // stage 3: squared length and mapping products
    logic [SW-1:0]        s3_reg;
    logic signed [UW-1:0] cxp3_reg, cym3_reg, cyp3_reg, cxm3_reg;
    logic signed [UW-1:0] dxp3_reg, dym3_reg, dyp3_reg, dxm3_reg;
    logic [M2-1:0]        min3_reg, max3_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_reg   <= SW'($unsigned(sqx2_reg)) + SW'($unsigned(sqy2_reg));
            cxp3_reg <= ecx2_reg * p2_reg;
            cym3_reg <= ecy2_reg * m2_reg;
            cyp3_reg <= ecy2_reg * p2_reg;
            cxm3_reg <= ecx2_reg * m2_reg;
            dxp3_reg <= edx2_reg * p2_reg;
            dym3_reg <= edy2_reg * m2_reg;
            dyp3_reg <= edy2_reg * p2_reg;
            dxm3_reg <= edx2_reg * m2_reg;
            min3_reg <= min2_reg;
            max3_reg <= max2_reg;
            idx3_reg <= idx2_reg;
        end
    end

    // stage 4: numerators and length range test
    logic [SW-1:0]        s4_reg;
    logic signed [UW-1:0] uc4_reg, vc4_reg, ud4_reg, vd4_reg;
    logic                 ab_bad4_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s4_reg      <= s3_reg;
            uc4_reg     <= cxp3_reg + cym3_reg;
            vc4_reg     <= cyp3_reg - cxm3_reg;
            ud4_reg     <= dxp3_reg + dym3_reg;
            vd4_reg     <= dyp3_reg - dxm3_reg;
            ab_bad4_reg <= (s3_reg == '0) || (MW'(s3_reg) < MW'(min3_reg))
                        || (MW'(s3_reg) > MW'(max3_reg));
            idx4_reg    <= idx3_reg;
        end
    end

    // stage 5: box test, divider operands
    logic signed [UW-1:0] s_wide;
    logic                 in_box;
    logic [SW-1:0]        s5_reg;
    logic [SW-1:0]        n5_reg [4];
    logic [1:0]           st5_reg;

    assign s_wide = $signed({2'b00, s4_reg});
    assign in_box = (uc4_reg > 0) && (uc4_reg < s_wide) && (vc4_reg > 0) && (vc4_reg < s_wide)
                 && (ud4_reg > 0) && (ud4_reg < s_wide) && (vd4_reg > 0) && (vd4_reg < s_wide);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s5_reg    <= s4_reg;
            n5_reg[0] <= uc4_reg[SW-1:0];
            n5_reg[1] <= vc4_reg[SW-1:0];
            n5_reg[2] <= ud4_reg[SW-1:0];
            n5_reg[3] <= vd4_reg[SW-1:0];
            st5_reg   <= ab_bad4_reg ? ST_AB_RANGE : (in_box ? ST_OK : ST_BOX);
            idx5_reg  <= idx4_reg;
        end
    end

    // code division
    logic          dv_valid;
    logic [FB-1:0] dv_q [4];
    logic [PW-1:0] dv_pay;

    qghc_div_pipe #(
        .SW (SW),
        .FB (FB),
        .PW (PW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (v_reg[4]),
        .in_s      (s5_reg),
        .in_n      (n5_reg),
        .in_pay    ({st5_reg, idx5_reg}),
        .out_valid (dv_valid),
        .out_q     (dv_q),
        .out_pay   (dv_pay)
    );

    // result serialiser: one quad record, up to four transfers
    logic          hold_reg;
    logic [1:0]    beat_reg;
    logic [1:0]    st_reg;
    logic [FB-1:0] q_reg [4];
    logic [IB-1:0] ia_reg, ib_reg, ic_reg, id_reg;
    logic          last_beat, fin, load;

    assign last_beat = (st_reg != ST_OK) || (beat_reg == ORD_BADC);
    assign fin       = hold_reg && code_out.ready && last_beat;
    assign load      = dv_valid && (!hold_reg || fin);
    assign adv       = !dv_valid || load;
    assign quad_in.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg <= 1'b0;
            beat_reg <= ORD_ABCD;
        end
        else if (load)
        begin
            hold_reg <= 1'b1;
            beat_reg <= ORD_ABCD;
        end
        else if (hold_reg && code_out.ready)
        begin
            if (last_beat)
            begin
                hold_reg <= 1'b0;
            end
            else
            begin
                beat_reg <= beat_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            st_reg <= dv_pay[PW-1 -: 2];
            ia_reg <= dv_pay[4*IB-1 -: IB];
            ib_reg <= dv_pay[3*IB-1 -: IB];
            ic_reg <= dv_pay[2*IB-1 -: IB];
            id_reg <= dv_pay[IB-1:0];
            for (int j = 0; j < 4; j++)
            begin
                q_reg[j] <= dv_q[j];
            end
        end
    end

    // result fields for the current order
    logic [FB:0] c_plain [4];
    logic [FB:0] c_flip [4];
    logic        ok;

    always_comb
    begin
        for (int j = 0; j < 4; j++)
        begin
            c_plain[j] = {1'b0, q_reg[j]};
            c_flip[j]  = {1'b1, {FB{1'b0}}} - {1'b0, q_reg[j]};
        end
    end

    assign ok = (st_reg == ST_OK);
    assign code_out.valid  = hold_reg;
    assign code_out.status = st_reg;
    assign code_out.order  = ok ? beat_reg : ORD_ABCD;
    assign code_out.last   = last_beat;

    always_comb
    begin
        code_out.first_star  = ia_reg;
        code_out.second_star = ib_reg;
        code_out.third_star  = ic_reg;
        code_out.fourth_star = id_reg;
        code_out.code_0 = '0;
        code_out.code_1 = '0;
        code_out.code_2 = '0;
        code_out.code_3 = '0;
        if (ok)
        begin
            case (beat_reg)
                ORD_ABCD:
                begin
                    code_out.code_0 = c_plain[0];
                    code_out.code_1 = c_plain[1];
                    code_out.code_2 = c_plain[2];
                    code_out.code_3 = c_plain[3];
                end
                ORD_BACD:
                begin
                    code_out.code_0 = c_flip[0];
                    code_out.code_1 = c_flip[1];
                    code_out.code_2 = c_flip[2];
                    code_out.code_3 = c_flip[3];
                    code_out.first_star  = ib_reg;
                    code_out.second_star = ia_reg;
                end
                ORD_ABDC:
                begin
                    code_out.code_0 = c_plain[2];
                    code_out.code_1 = c_plain[3];
                    code_out.code_2 = c_plain[0];
                    code_out.code_3 = c_plain[1];
                    code_out.third_star  = id_reg;
                    code_out.fourth_star = ic_reg;
                end
                ORD_BADC:
                begin
                    code_out.code_0 = c_flip[2];
                    code_out.code_1 = c_flip[3];
                    code_out.code_2 = c_flip[0];
                    code_out.code_3 = c_flip[1];
                    code_out.first_star  = ib_reg;
                    code_out.second_star = ia_reg;
                    code_out.third_star  = id_reg;
                    code_out.fourth_star = ic_reg;
                end
                default: ;
            endcase
        end
    end

`ifndef SYNTH
    // a rejected quad gives one closing result
    a_reject_last: assert property (@(posedge clk) disable iff (!rst_n)
        (code_out.valid && code_out.status != ST_OK) |-> code_out.last)
        else $error("rejected quad result without last");

    // only an accepted quad walks through the other orders
    a_order_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (code_out.valid && code_out.order != ORD_ABCD) |-> (code_out.status == ST_OK))
        else $error("non-ABCD order on a rejected quad");

    // a finished record waiting on the serialiser stalls the whole pipeline
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (dv_valid && hold_reg && !fin) |-> !quad_in.ready)
        else $error("input accepted while the pipeline is stalled");

    // orders advance one step per transfer
    a_beat_step: assert property (@(posedge clk) disable iff (!rst_n)
        (code_out.valid && code_out.ready && !code_out.last) |=>
        (code_out.valid && beat_reg == $past(beat_reg) + 2'd1))
        else $error("order sequence skipped");
`endif

endmodule
`default_nettype wire

// File: dv/quad_geometric_hash_code_tb.sv
`timescale 1ns / 1ps
module quad_geometric_hash_code_tb;
    import qghc_pkg::*;

    localparam int CB = COORD_BITS_DEF;
    localparam int FB = CODE_FRAC_BITS_DEF;
    localparam int IB = INDEX_BITS_DEF;
    localparam int LATENCY = FB + 5;

    typedef struct packed {
        logic [CB-1:0] ax, ay, bx, by, cx, cy, px, py;
        logic [IB-1:0] ia, ib, ic, id;
    } quad_t;

    typedef struct packed {
        logic [1:0]    status;
        logic [1:0]    order;
        logic [FB:0]   c0, c1, c2, c3;
        logic [IB-1:0] s0, s1, s2, s3;
        logic          last;
    } code_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    qghc_quad_if #(.CB(CB), .IB(IB)) quad_ch ();
    qghc_code_if #(.FB(FB), .IB(IB)) code_ch ();
    qghc_cfg_if #(.XB(CFG_IDX_BITS), .DB(CFG_BITS)) cfg_ch ();

    quad_geometric_hash_code u_top (
        .clk(clk),
        .rst_n(rst_n),
        .quad_in(quad_ch.sink),
        .code_out(code_ch.source),
        .cfg(cfg_ch.sink)
    );

    always #1 clk = ~clk;

    // shadow registers
    logic [CFG_BITS-1:0] min_ab_q;
    logic [CFG_BITS-1:0] max_ab_q;

    code_t expected_codes[$];
    int mismatches = 0;
    int hold_off = 0;       // long receiver hold-off, in cycles
    int rx_wait = 0;        // receiver wait before the next transfer, in cycles
    bit rx_random = 1'b1;

    initial
    begin
        quad_ch.valid = 1'b0;
        quad_ch.ax = '0; quad_ch.ay = '0; quad_ch.bx = '0; quad_ch.by_pos = '0;
        quad_ch.cx = '0; quad_ch.cy = '0; quad_ch.dx_pos = '0; quad_ch.dy_pos = '0;
        quad_ch.a_index = '0; quad_ch.b_index = '0;
        quad_ch.c_index = '0; quad_ch.d_index = '0;
        code_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        min_ab_q = '0;
        max_ab_q = '1;
    end

    // floor(num * 2^FB / den), exact long division
    function automatic logic [FB:0] frac_code(longint unsigned num, longint unsigned den);
        longint unsigned r;
        logic [FB:0] q;
        r = num;
        q = '0;
        for (int i = 0; i < FB; i++)
        begin
            r = r << 1;
            q = q << 1;
            if (r >= den)
            begin
                r -= den;
                q[0] = 1'b1;
            end
        end
        return q;
    endfunction

    // map a point into the AB frame; 0 when outside the open unit box
    function automatic bit map_to_frame(longint ex, longint ey, longint dx, longint dy,
                                        longint s, output logic [FB:0] qx,
                                        output logic [FB:0] qy);
        longint u, v;
        u = ex * (dx + dy) + ey * (dy - dx);
        v = ey * (dx + dy) - ex * (dy - dx);
        qx = '0;
        qy = '0;
        if (u <= 0 || u >= s || v <= 0 || v >= s)
            return 1'b0;
        qx = frac_code(u, s);
        qy = frac_code(v, s);
        return 1'b1;
    endfunction

    // predict the codes of one quad
    task automatic predict_codes(quad_t q);
        longint ax, ay, dx, dy, s;
        longint unsigned lo, hi;
        logic [FB:0] ccx, ccy, cdx, cdy, one;
        bit c_in, d_in;
        code_t r;
        one = {1'b1, {FB{1'b0}}};
        ax = longint'(signed'(q.ax));
        ay = longint'(signed'(q.ay));
        dx = longint'(signed'(q.bx)) - ax;
        dy = longint'(signed'(q.by)) - ay;
        s = dx * dx + dy * dy;
        lo = longint'(min_ab_q) * longint'(min_ab_q);
        hi = longint'(max_ab_q) * longint'(max_ab_q);
        r = '{status: ST_OK, order: ORD_ABCD, c0: '0, c1: '0, c2: '0, c3: '0,
              s0: q.ia, s1: q.ib, s2: q.ic, s3: q.id, last: 1'b1};
        if (s == 0 || longint'(s) < 0 || s < lo || s > hi)
        begin
            r.status = ST_AB_RANGE;
            expected_codes.push_back(r);
            return;
        end
        c_in = map_to_frame(longint'(signed'(q.cx)) - ax, longint'(signed'(q.cy)) - ay,
                            dx, dy, s, ccx, ccy);
        d_in = c_in && map_to_frame(longint'(signed'(q.px)) - ax,
                                    longint'(signed'(q.py)) - ay, dx, dy, s, cdx, cdy);
        if (!d_in)
        begin
            r.status = ST_BOX;
            expected_codes.push_back(r);
            return;
        end
        expected_codes.push_back('{ST_OK, ORD_ABCD, ccx, ccy, cdx, cdy,
                                   q.ia, q.ib, q.ic, q.id, 1'b0});
        expected_codes.push_back('{ST_OK, ORD_BACD, one - ccx, one - ccy, one - cdx,
                                   one - cdy, q.ib, q.ia, q.ic, q.id, 1'b0});
        expected_codes.push_back('{ST_OK, ORD_ABDC, cdx, cdy, ccx, ccy,
                                   q.ia, q.ib, q.id, q.ic, 1'b0});
        expected_codes.push_back('{ST_OK, ORD_BADC, one - cdx, one - cdy, one - ccx,
                                   one - ccy, q.ib, q.ia, q.id, q.ic, 1'b1});
    endtask

    // send one quad, with an optional random gap first; valid stays up until the next gap or drain
    task automatic send_quad(quad_t q, bit gaps = 1'b1);
        int gap;
        gap = gaps ? (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17)) : 0;
        if (gap != 0)
        begin
            quad_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        quad_ch.valid <= 1'b1;
        quad_ch.ax <= q.ax; quad_ch.ay <= q.ay;
        quad_ch.bx <= q.bx; quad_ch.by_pos <= q.by;
        quad_ch.cx <= q.cx; quad_ch.cy <= q.cy;
        quad_ch.dx_pos <= q.px; quad_ch.dy_pos <= q.py;
        quad_ch.a_index <= q.ia; quad_ch.b_index <= q.ib;
        quad_ch.c_index <= q.ic; quad_ch.d_index <= q.id;
        do
            @(posedge clk);
        while (!quad_ch.ready);
        predict_codes(q);
    endtask

    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_BITS-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= val;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        if (idx == REG_MIN_AB)
            min_ab_q = val;
        else if (idx == REG_MAX_AB)
            max_ab_q = val;
        @(posedge clk);
    endtask

    task automatic drain();
        quad_ch.valid <= 1'b0;
        while (expected_codes.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    // A at a random point, B offset, C and D placed at random near the box
    function automatic quad_t good_quad(int span);
        quad_t q;
        int ax, ay, d;
        ax = $urandom_range(0, 4000000) - 2000000;
        ay = $urandom_range(0, 4000000) - 2000000;
        d = $urandom_range(1, span);
        q.ax = CB'(ax); q.ay = CB'(ay);
        q.bx = CB'(ax + d); q.by = CB'(ay + int'($urandom_range(0, d)) - d / 2);
        // points near the square between A and B
        q.cx = CB'(ax + int'($urandom_range(0, d)));
        q.cy = CB'(ay + int'($urandom_range(0, d)) - d / 2);
        q.px = CB'(ax + int'($urandom_range(0, d)));
        q.py = CB'(ay + int'($urandom_range(0, d)) - d / 2);
        q.ia = IB'($urandom); q.ib = IB'($urandom);
        q.ic = IB'($urandom); q.id = IB'($urandom);
        return q;
    endfunction

    function automatic quad_t noise_quad();
        quad_t q;
        logic [255:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom,
               $urandom, $urandom, $urandom, $urandom};
        q = raw[$bits(quad_t)-1:0];
        return q;
    endfunction

    // result checker and receiver stalls
    always @(posedge clk)
    begin
        code_t got, exp_r;
        int wait_n;
        if (rst_n)
        begin
            if (code_ch.valid && code_ch.ready)
            begin
                got = '{code_ch.status, code_ch.order, code_ch.code_0, code_ch.code_1,
                        code_ch.code_2, code_ch.code_3, code_ch.first_star,
                        code_ch.second_star, code_ch.third_star, code_ch.fourth_star,
                        code_ch.last};
                if (expected_codes.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected code transfer %p", got);
                end
                else
                begin
                    exp_r = expected_codes.pop_front();
                    if (got !== exp_r)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("code mismatch: expected %p actual %p", exp_r, got);
                    end
                end
            end
            if (hold_off > 0)
            begin
                hold_off <= hold_off - 1;
                code_ch.ready <= 1'b0;
            end
            else if (!rx_random)
                code_ch.ready <= 1'b1;
            else if (code_ch.valid && code_ch.ready)
            begin
                // draw the wait before the next transfer
                wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
                rx_wait <= wait_n;
                code_ch.ready <= (wait_n == 0);
            end
            else if (rx_wait > 0)
            begin
                rx_wait <= rx_wait - 1;
                code_ch.ready <= (rx_wait == 1);
            end
            else
                code_ch.ready <= 1'b1;
        end
    end

    task automatic test_directed();
        quad_t q;
        q = '{ax: 0, ay: 0, bx: 256, by: 0, cx: 128, cy: 0, px: 100, py: 20,
              ia: 0, ib: 1023, ic: 512, id: 1};
        send_quad(q);                           // accepted
        q.bx = 0;
        send_quad(q);                           // zero AB length
        q.bx = 256; q.cx = 0;
        send_quad(q);                           // C on the box corner
        q.cx = 128; q.cy = 128;
        send_quad(q);                           // C on another box corner
        q.cy = 0; q.px = 512;
        send_quad(q);                           // D outside
        q = '{ax: 24'h800000, ay: 24'h800000, bx: 24'h7fffff, by: 24'h7fffff,
              cx: 24'h000000, cy: 24'h000000, px: 24'h100000, py: 24'hf00000,
              ia: 1023, ib: 0, ic: 1, id: 1022};
        send_quad(q);                           // field extremes
        q = '{ax: 24'h7fffff, ay: 24'h800000, bx: 24'h800000, by: 24'h7fffff,
              cx: 24'h7fffff, cy: 24'h7fffff, px: 24'h800000, py: 24'h800000,
              ia: 341, ib: 682, ic: 1023, id: 0};
        send_quad(q);
        q = '{ax: 5, ay: -7, bx: 6, by: -7, cx: 5, cy: -7, px: 6, py: -6,
              ia: 3, ib: 4, ic: 5, id: 6};
        send_quad(q);                           // unit AB length
        repeat (6) send_quad(good_quad(5000));
        drain();
    endtask

    task automatic test_ab_limits();
        quad_t q;
        // length at and just beyond the limits
        write_reg(REG_MIN_AB, 24'd256);
        write_reg(REG_MAX_AB, 24'd512);
        q = '{ax: 0, ay: 0, bx: 256, by: 0, cx: 128, cy: 0, px: 100, py: 20,
              ia: 7, ib: 8, ic: 9, id: 10};
        send_quad(q);
        q.bx = 255; send_quad(q);
        q.bx = 512; send_quad(q);
        q.bx = 513; send_quad(q);
        repeat (10) send_quad(good_quad(700));
        drain();
        // minimum above maximum
        write_reg(REG_MIN_AB, 24'hffffff);
        write_reg(REG_MAX_AB, 24'd0);
        repeat (8) send_quad(good_quad(3000));
        drain();
        write_reg(2'd2, 24'd1);                 // out of range index
        write_reg(2'd3, 24'd1);
        write_reg(REG_MIN_AB, 24'd0);
        write_reg(REG_MAX_AB, 24'hffffff);
        repeat (6) send_quad(good_quad(3000));
        drain();
    endtask

    task automatic test_random();
        for (int i = 0; i < 140; i++)
        begin
            if (i == 70)
            begin
                drain();
                write_reg(REG_MIN_AB, CFG_BITS'($urandom_range(0, 64)));
                write_reg(REG_MAX_AB, CFG_BITS'($urandom_range(3000, 24'hffffff)));
            end
            if ($urandom_range(0, 9) < 7)
                send_quad(good_quad(($urandom_range(0, 9) == 0) ? 4000000 : 3000));
            else
                send_quad(noise_quad());
        end
        drain();
    endtask

    // back pressure, then a pause until empty, then a run with the receiver always ready
    task automatic test_backpressure();
        hold_off = 300;
        repeat (30) send_quad(good_quad(3000), 1'b0);
        drain();
        rx_random = 1'b0;
        repeat (10) send_quad(good_quad(3000), 1'b0);
        rx_random = 1'b1;
        drain();
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_ab_limits();
        test_random();
        test_backpressure();
        if (mismatches == 0 && expected_codes.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #500000;
        $display("end of test: mismatches");
        $finish;
    end
endmodule
